[src/bsa_pkg.sv]
// ============================================================================
// bsa_pkg
// Shared types, constants and helper functions for the barometric
// altitude pipeline.
// ============================================================================
package bsa_pkg;

    // reset value of the reference pressure, 101325 Pa in Q6
    localparam logic [23:0] REF_PRESS_RESET   = 24'd6484800;
    // round(2^24 / 5.257)
    localparam logic [21:0] INV_EXP_Q24       = 22'd3191405;
    // 273.15 K in Q16
    localparam logic [25:0] KELVIN_OFFSET_Q16 = 26'd17901158;
    // 100 / 0.0065 in Q16
    localparam logic [29:0] CM_PER_KELVIN_Q16 = 30'd1008246154;
    // 1.0 in Q30
    localparam logic [30:0] ONE_Q30           = 31'h4000_0000;

    // per-item sideband that travels beside the arithmetic cells
    typedef struct packed {
        logic [23:0] traw;    // temperature word
        logic [23:0] praw;    // pressure word
        logic [23:0] p0;      // reference pressure at the time of the request
        logic        pzero;   // pressure is zero
        logic        rzero;   // reference pressure is zero
        logic [54:0] wprod;   // Tk * cm-per-kelvin, before rounding
        logic [31:0] w;       // cm per unit y, Q8
        logic [3:0]  nb;      // integer part of the exponent, biased by 8
        logic        yneg;    // y below zero
    } t_side;

    // one result as it sits in the output register or the skid stage
    typedef struct packed {
        logic [79:0] tdata;
        logic        tuser;
    } t_out;

    // index of the top set bit, 0 for a zero word
    function automatic logic [4:0] lead_one(input logic [23:0] x);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (x[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    // integer square root, used only to build constants
    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] xx;
        r  = 64'd0;
        xx = x;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (xx >= r + b) begin
                xx = xx - (r + b);
                r  = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // 2^(2^-k) in Q30, by repeated square roots of 2.0
    function automatic logic [30:0] exp_coef(input int k);
        logic [63:0] c;
        c = 64'd2 << 30;
        for (int j = 1; j <= 32; j++) begin
            if (j <= k) begin
                c = isqrt(c << 30);
            end
        end
        return c[30:0];
    endfunction

endpackage

[src/baro_sample_to_altitude.sv]
// ============================================================================
// baro_sample_to_altitude
// Assembles temperature and pressure from sensor bytes and computes the
// hypsometric altitude above a reference pressure, one sample per clock when not stalled.
// ============================================================================
//  channel   dir  signals                        content
//  s_axis    in   tvalid/tready/tdata[47:0]      six sensor data bytes
//  m_axis    out  tvalid/tready/tdata[79:0]/tuser temperature, pressure, altitude
//  cfg       in   i_cfg_wr_en/i_cfg_wr_data      reference pressure, Q6 Pa
//
//  One request per clock while the skid stage is empty; the data passes the
//  chain of log2 squaring cells and exp2 multiply cells.
//  Reset clears all valid flags and loads a reference pressure of 101325 Pa.
//  An output register plus a skid stage hold results; the pipeline freezes
//  only while the skid stage is full, so s_axis_tready is a register output.
// ============================================================================
module baro_sample_to_altitude #(
    parameter int APPROX_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] temp_byte_low, [15:8] temp_byte_mid, [23:16] temp_byte_high,
    // [31:24] press_byte_low, [39:32] press_byte_mid, [47:40] press_byte_high
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [23:0] temperature_q16, [47:24] pressure_q6, [79:48] altitude_cm
    output logic [79:0] m_axis_tdata,
    // [0] pressure_zero
    output logic [0:0]  m_axis_tuser
);

    localparam int S     = APPROX_STAGES;
    localparam int VW    = S + 5;
    localparam int ST_B  = 1;
    localparam int ST_C  = S + 2;
    localparam int ST_D  = S + 3;
    localparam int ST_XL = 2 * S + 3;
    localparam int ST_E  = 2 * S + 4;
    localparam int ST_F  = 2 * S + 5;
    localparam int NST   = ST_F + 1;

    logic [23:0]          r_ref;
    logic [NST-1:0]       r_vld;
    bsa_pkg::t_side       r_side [0:NST-1];
    bsa_pkg::t_side       n_side [0:NST-1];
    logic                 w_ce;

    bsa_pkg::t_side       n_side_a;
    logic [4:0]           w_top_p;
    logic [4:0]           w_top_r;
    logic [25:0]          w_tks;
    logic [54:0]          n_wprod;
    logic [30:0]          r_b_mp;
    logic [30:0]          r_b_mr;
    logic [VW-1:0]        r_b_vp;
    logic [VW-1:0]        r_b_vr;

    logic [30:0]          w_mp [0:S];
    logic [30:0]          w_mr [0:S];
    logic [VW-1:0]        w_vp [0:S];
    logic [VW-1:0]        w_vr [0:S];

    logic [VW:0]          w_l;
    logic [VW-1:0]        w_lm;
    logic [VW+21:0]       n_lprod;
    logic [55:0]          w_wsum;
    logic [VW+21:0]       r_c_lprod;
    logic                 r_c_neg;

    logic [59:0]          w_esh;
    logic [59:0]          w_esum;
    logic [35:0]          w_em;
    logic [35:0]          w_ue;
    logic [31:0]          r_d_f;

    logic [31:0]          w_f   [0:S];
    logic [30:0]          w_acc [0:S];

    logic [37:0]          w_v;
    logic [38:0]          w_y;
    logic [37:0]          w_ym;
    logic [38:0]          w_yr;
    logic [30:0]          r_e_yq;
    logic [62:0]          r_f_pa;

    logic [63:0]          w_asum;
    logic [33:0]          w_am;
    logic [33:0]          w_lim;
    logic [31:0]          w_alt;
    bsa_pkg::t_out        n_out;
    bsa_pkg::t_out        r_out;
    bsa_pkg::t_out        r_skid;
    logic                 r_ov;
    logic                 r_skid_v;
    logic                 w_take;

    // pipeline advances unless the skid stage is occupied
    assign w_ce          = !r_skid_v;
    assign s_axis_tready = w_ce;
    assign w_take        = r_ov && m_axis_tready;

    // reference pressure register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= bsa_pkg::REF_PRESS_RESET;
        end else if (i_cfg_wr_en) begin
            r_ref <= i_cfg_wr_data;
        end
    end

    // stage A: capture the words
    always_comb begin
        n_side_a       = '0;
        n_side_a.traw  = s_axis_tdata[23:0];
        n_side_a.praw  = s_axis_tdata[47:24];
        n_side_a.p0    = r_ref;
        n_side_a.pzero = (s_axis_tdata[47:24] == 24'd0);
        n_side_a.rzero = (r_ref == 24'd0);
    end

    // stage B: normalize both pressures, start the temperature product
    always_comb begin
        w_top_p = bsa_pkg::lead_one(r_side[0].praw);
        w_top_r = bsa_pkg::lead_one(r_side[0].p0);
        w_tks   = {{2{r_side[0].traw[23]}}, r_side[0].traw} + bsa_pkg::KELVIN_OFFSET_Q16;
        n_wprod = {30'd0, w_tks[24:0]} * {25'd0, bsa_pkg::CM_PER_KELVIN_Q16};
    end

    // valid flags and sideband
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // next sideband: shift by one stage, fill in the fields computed on the way
    always_comb begin
        n_side[0] = n_side_a;
        for (int i = 1; i < NST; i++) begin
            n_side[i] = r_side[i-1];
        end
        n_side[ST_B].wprod = n_wprod;
        n_side[ST_C].w     = w_wsum[55:24];
        n_side[ST_D].nb    = w_ue[35:32];
        n_side[ST_E].yneg  = w_y[38] && !r_side[ST_XL].rzero || r_side[ST_XL].rzero;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < NST; i++) begin
                r_side[i] <= n_side[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_b_mp <= 31'({7'd0, r_side[0].praw} << (5'd30 - w_top_p));
            r_b_mr <= 31'({7'd0, r_side[0].p0} << (5'd30 - w_top_r));
            r_b_vp <= VW'(w_top_p);
            r_b_vr <= VW'(w_top_r);
        end
    end

    // log2 squaring chain
    assign w_mp[0] = r_b_mp;
    assign w_mr[0] = r_b_mr;
    assign w_vp[0] = r_b_vp;
    assign w_vr[0] = r_b_vr;

    for (genvar g = 0; g < S; g++) begin : g_log
        bsa_log2_cell #(.VW(VW)) u_cell (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_m_p (w_mp[g]),
            .i_m_r (w_mr[g]),
            .i_v_p (w_vp[g]),
            .i_v_r (w_vr[g]),
            .o_m_p (w_mp[g+1]),
            .o_m_r (w_mr[g+1]),
            .o_v_p (w_vp[g+1]),
            .o_v_r (w_vr[g+1])
        );
    end

    // stage C: log difference times 1/5.257, round the scale factor
    always_comb begin
        w_l     = {1'b0, w_vr[S]} - {1'b0, w_vp[S]};
        w_lm    = w_l[VW] ? VW'(-w_l) : w_l[VW-1:0];
        n_lprod = {22'd0, w_lm} * {VW'(0), bsa_pkg::INV_EXP_Q24};
        w_wsum  = {1'b0, r_side[ST_C-1].wprod} + 56'h80_0000;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_c_lprod <= n_lprod;
            r_c_neg   <= w_l[VW];
        end
    end

    // stage D: exponent to Q32, split into integer and fraction
    always_comb begin
        w_esh  = 60'(r_c_lprod) << (32 - S);
        w_esum = w_esh + 60'h80_0000;
        w_em   = w_esum[59:24];
        w_ue   = r_c_neg ? (36'h8_0000_0000 - w_em) : (36'h8_0000_0000 + w_em);
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_d_f <= w_ue[31:0];
        end
    end

    // exp2 product chain
    assign w_f[0]   = r_d_f;
    assign w_acc[0] = bsa_pkg::ONE_Q30;

    for (genvar g = 0; g < S; g++) begin : g_exp
        bsa_exp2_cell #(.K(g + 1)) u_cell (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_f   (w_f[g]),
            .i_acc (w_acc[g]),
            .o_f   (w_f[g+1]),
            .o_acc (w_acc[g+1])
        );
    end

    // stage E: apply integer part, subtract one, round to Q22
    always_comb begin
        if (r_side[ST_XL].nb[3]) begin
            w_v = 38'(w_acc[S]) << r_side[ST_XL].nb[2:0];
        end else begin
            w_v = 38'(w_acc[S]) >> (4'd8 - r_side[ST_XL].nb);
        end
        w_y  = {1'b0, w_v} - 39'(bsa_pkg::ONE_Q30);
        if (r_side[ST_XL].rzero) begin
            w_ym = 38'(bsa_pkg::ONE_Q30);
        end else begin
            w_ym = w_y[38] ? 38'(-w_y) : w_y[37:0];
        end
        w_yr = {1'b0, w_ym} + 39'd128;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_e_yq <= w_yr[38:8];
        end
    end

    // stage F: scale by temperature
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_f_pa <= {32'd0, r_e_yq} * {31'd0, r_side[ST_E].w};
        end
    end

    // result: round, saturate, apply sign
    always_comb begin
        w_asum = {1'b0, r_f_pa} + 64'h2000_0000;
        w_am   = w_asum[63:30];
        w_lim  = r_side[ST_F].yneg ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
        if (w_am > w_lim) begin
            w_am = w_lim;
        end
        w_alt = r_side[ST_F].yneg ? -w_am[31:0] : w_am[31:0];
        if (r_side[ST_F].pzero) begin
            w_alt = 32'd0;
        end
        n_out.tdata = {w_alt, r_side[ST_F].praw, r_side[ST_F].traw};
        n_out.tuser = r_side[ST_F].pzero;
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_vld[NST-1]) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (r_vld[NST-1]) begin
            if (!r_ov || w_take) begin
                r_out <= n_out;
            end else begin
                r_skid <= n_out;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out.tdata;
    assign m_axis_tuser  = r_out.tuser;

    // skid stage is only filled behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid stage full with empty output register");

    // an accepted request enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted request not captured");

    // pipeline frozen while the skid stage is full
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    // zero pressure never reports an altitude
    a_zero_alt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[79:48] == 32'd0))
        else $error("altitude reported for zero pressure");

endmodule

[src/bsa_log2_cell.sv]
// ============================================================================
// bsa_log2_cell
// One squaring step of the log2 iteration, for the pressure lane and the
// reference lane side by side. Yields one fraction bit per lane.
// ============================================================================
module bsa_log2_cell #(
    parameter int VW = 21
) (
    input  logic          i_clk,
    input  logic          i_ce,
    input  logic [30:0]   i_m_p,
    input  logic [30:0]   i_m_r,
    input  logic [VW-1:0] i_v_p,
    input  logic [VW-1:0] i_v_r,
    output logic [30:0]   o_m_p,
    output logic [30:0]   o_m_r,
    output logic [VW-1:0] o_v_p,
    output logic [VW-1:0] o_v_r
);

    logic [61:0]   w_sq_p;
    logic [61:0]   w_sq_r;
    logic [30:0]   n_m_p;
    logic [30:0]   n_m_r;
    logic [VW-1:0] n_v_p;
    logic [VW-1:0] n_v_r;
    logic [30:0]   r_m_p;
    logic [30:0]   r_m_r;
    logic [VW-1:0] r_v_p;
    logic [VW-1:0] r_v_r;

    // square, then halve when the mantissa reached 2.0
    always_comb begin
        w_sq_p = {31'd0, i_m_p} * {31'd0, i_m_p};
        w_sq_r = {31'd0, i_m_r} * {31'd0, i_m_r};
        n_m_p  = w_sq_p[61] ? w_sq_p[61:31] : w_sq_p[60:30];
        n_m_r  = w_sq_r[61] ? w_sq_r[61:31] : w_sq_r[60:30];
        n_v_p  = {i_v_p[VW-2:0], w_sq_p[61]};
        n_v_r  = {i_v_r[VW-2:0], w_sq_r[61]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_m_p <= n_m_p;
            r_m_r <= n_m_r;
            r_v_p <= n_v_p;
            r_v_r <= n_v_r;
        end
    end

    assign o_m_p = r_m_p;
    assign o_m_r = r_m_r;
    assign o_v_p = r_v_p;
    assign o_v_r = r_v_r;

endmodule

[src/bsa_exp2_cell.sv]
// ============================================================================
// bsa_exp2_cell
// One step of the exp2 product: multiplies the accumulator by 2^(2^-K)
// when fraction bit 32-K of the exponent is set.
// ============================================================================
module bsa_exp2_cell #(
    parameter int K = 1
) (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [31:0] i_f,
    input  logic [30:0] i_acc,
    output logic [31:0] o_f,
    output logic [30:0] o_acc
);

    localparam logic [30:0] COEF = bsa_pkg::exp_coef(K);

    logic [61:0] w_prod;
    logic [30:0] n_acc;
    logic [31:0] r_f;
    logic [30:0] r_acc;

    // conditional multiply by the stage coefficient
    always_comb begin
        w_prod = {31'd0, i_acc} * {31'd0, COEF};
        n_acc  = i_f[32-K] ? w_prod[60:30] : i_acc;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_f   <= i_f;
            r_acc <= n_acc;
        end
    end

    assign o_f   = r_f;
    assign o_acc = r_acc;

endmodule

[bench/testbench.sv]
// ============================================================================
// testbench
// Drives sensor samples into the barometric altitude pipeline and checks every
// result against a bit-exact fixed-point altitude predictor or a typed value.
// Covers several reference pressures, including the extremes, under random
// source gaps and sink stalls.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES  = 16;
    localparam int LATENCY = 2 * STAGES + 7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [23:0] i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [23:0] temperature word, [47:24] pressure word
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [23:0] temperature_q16, [47:24] pressure_q6, [79:48] altitude_cm
    logic [79:0] m_axis_tdata;
    // [0] pressure_zero
    logic [0:0]  m_axis_tuser;

    typedef struct packed {
        logic [23:0]        temp;
        logic [23:0]        press;
        logic signed [31:0] alt;
        logic               pzero;
    } t_sample_result;

    // directed row: typed expectation used only where has_alt is set
    typedef struct packed {
        logic [23:0]        temp;
        logic [23:0]        press;
        logic               has_alt;
        logic signed [31:0] alt;
    } t_sample_row;

    t_sample_result altitude_queue[$];
    logic [23:0]    ref_press;
    int             mismatch_count;
    int             burst_left;

    baro_sample_to_altitude #(.APPROX_STAGES(STAGES)) dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------- predictor
    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned res, bits, v;
        res  = 0;
        v    = x;
        bits = 64'd1 << 62;
        while (bits > v) bits >>= 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v   = v - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits >>= 2;
        end
        return res;
    endfunction

    // log2 of a nonzero 24-bit word, Q32
    function automatic longint unsigned log2_word(input logic [23:0] x);
        int              top;
        longint unsigned m, frac;
        top = 23;
        while (top > 0 && !x[top]) top--;
        m    = longint'(x) << (30 - top);
        frac = 0;
        for (int i = 1; i <= STAGES; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m    = m >> 1;
                frac = frac | (64'd1 << (STAGES - i));
            end
        end
        return ((longint'(top) << STAGES) | frac) << (32 - STAGES);
    endfunction

    // 2^e - 1 in Q30 for e in Q32
    function automatic longint pow2_minus_one(input longint e);
        longint unsigned ue, f, c, acc, v;
        int              n;
        ue  = e + (64'sd8 <<< 32);
        n   = int'(ue >> 32) - 8;
        f   = ue & 64'hFFFF_FFFF;
        c   = 64'd2 << 30;
        acc = 64'd1 << 30;
        for (int k = 1; k <= STAGES; k++) begin
            c = root64(c << 30);
            if ((f >> (32 - k)) & 1) acc = (acc * c) >> 30;
        end
        if (n >= 0) v = acc << (n & 7);
        else v = (-n > 40) ? 0 : (acc >> (-n));
        return longint'(v) - (longint'(1) << 30);
    endfunction

    function automatic t_sample_result predict_altitude(input logic [23:0] temp,
                                                        input logic [23:0] press,
                                                        input logic [23:0] p0);
        t_sample_result  r;
        longint          y, l, e, t;
        longint unsigned lm, em, tk, w, ym, yq, am, cap;
        r.temp  = temp;
        r.press = press;
        r.alt   = '0;
        r.pzero = (press == 24'd0);
        if (!r.pzero) begin
            if (p0 == 24'd0) begin
                y = -(longint'(1) << 30);
            end else begin
                l  = longint'(log2_word(p0)) - longint'(log2_word(press));
                lm = (l < 0) ? -l : l;
                em = (lm * bsa_pkg::INV_EXP_Q24 + (64'd1 << 23)) >> 24;
                e  = (l < 0) ? -longint'(em) : longint'(em);
                y  = pow2_minus_one(e);
            end
            t   = longint'(signed'(temp));
            tk  = t + bsa_pkg::KELVIN_OFFSET_Q16;
            w   = (tk * bsa_pkg::CM_PER_KELVIN_Q16 + (64'd1 << 23)) >> 24;
            ym  = (y < 0) ? -y : y;
            yq  = (ym + 128) >> 8;
            am  = (yq * w + (64'd1 << 29)) >> 30;
            cap = 64'h7FFF_FFFF + ((y < 0) ? 1 : 0);
            if (am > cap) am = cap;
            r.alt = (y < 0) ? 32'(-longint'(am)) : 32'(am);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_sample_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (altitude_queue.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = altitude_queue.pop_front();
                if (m_axis_tdata[23:0] !== want.temp)
                    report_mismatch("temperature", m_axis_tdata[23:0], want.temp);
                if (m_axis_tdata[47:24] !== want.press)
                    report_mismatch("pressure", m_axis_tdata[47:24], want.press);
                if (m_axis_tdata[79:48] !== want.alt)
                    report_mismatch("altitude", signed'(m_axis_tdata[79:48]), want.alt);
                if (m_axis_tuser[0] !== want.pzero)
                    report_mismatch("zero flag", m_axis_tuser[0], want.pzero);
            end
        end
    end

    // sink stalls: the pattern is drawn anew whenever its timer runs out
    always @(posedge i_clk) begin
        int stall_mode, stall_timer;
        if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(50, 400);
        end
        stall_timer--;
        case (stall_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 7) != 0);
            end
        endcase
    end

    // ---------------------------------------------------------------- stimulus
    // one request, bursts with random gaps; expectation queued on acceptance
    task automatic send_sample(input logic [23:0] temp, input logic [23:0] press,
                               input logic has_alt, input logic signed [31:0] alt);
        t_sample_result want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {press, temp};
        want = predict_altitude(temp, press, ref_press);
        if (has_alt) want.alt = alt;
        do @(posedge i_clk); while (!s_axis_tready);
        altitude_queue.push_back(want);
    endtask

    task automatic write_reference(input logic [23:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (altitude_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        ref_press = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // pressure mostly near the reference, sometimes anywhere, tiny or zero
    function automatic logic [23:0] random_pressure();
        int          pick;
        logic [23:0] p;
        pick = $urandom_range(0, 19);
        if (pick == 0) p = 24'd0;
        else if (pick < 5) p = 24'($urandom());
        else if (pick < 7) p = 24'($urandom_range(1, 255));
        else begin
            p = ref_press + 24'($urandom_range(0, 2000000)) - 24'd1000000;
            if (ref_press < 24'd1000000 || ref_press > 24'd15777215) p = 24'($urandom());
        end
        return p;
    endfunction

    initial begin
        t_sample_row directed_rows[] = '{
            '{24'h000000, 24'h000000, 1'b1, 32'sd0},      // zero pressure
            '{24'hFFFFFF, 24'h000000, 1'b1, 32'sd0},
            '{24'h123456, bsa_pkg::REF_PRESS_RESET, 1'b1, 32'sd0}, // at reference
            '{24'h7FFFFF, bsa_pkg::REF_PRESS_RESET, 1'b1, 32'sd0},
            '{24'h800000, bsa_pkg::REF_PRESS_RESET, 1'b1, 32'sd0},
            '{24'h000000, 24'h000001, 1'b0, 32'sd0},      // tiny pressure
            '{24'h7FFFFF, 24'h000001, 1'b0, 32'sd0},
            '{24'h800000, 24'h000001, 1'b0, 32'sd0},
            '{24'h000000, 24'hFFFFFF, 1'b0, 32'sd0},      // full-scale pressure
            '{24'h7FFFFF, 24'hFFFFFF, 1'b0, 32'sd0},
            '{24'h800000, 24'hFFFFFF, 1'b0, 32'sd0},
            '{24'h190000, 24'h5A0000, 1'b0, 32'sd0},      // typical values
            '{24'h0A0000, 24'h4E2000, 1'b0, 32'sd0},
            '{24'hF60000, 24'h2BC000, 1'b0, 32'sd0},
            '{24'h000000, 24'h800000, 1'b0, 32'sd0},
            '{24'h000000, 24'h7FFFFF, 1'b0, 32'sd0},
            '{24'hAA55AA, 24'h55AA55, 1'b0, 32'sd0},
            '{24'h55AA55, 24'hAA55AA, 1'b0, 32'sd0}
        };
        logic [23:0] ref_values[5];

        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        mismatch_count = 0;
        burst_left     = 0;
        ref_press      = bsa_pkg::REF_PRESS_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows at the reset reference
        foreach (directed_rows[i])
            send_sample(directed_rows[i].temp, directed_rows[i].press,
                        directed_rows[i].has_alt, directed_rows[i].alt);

        // reference sweep: reset value, extremes, zero, then a random one
        ref_values = '{bsa_pkg::REF_PRESS_RESET, 24'd1, 24'hFFFFFF, 24'd0, 24'd0};
        ref_values[4] = 24'($urandom_range(1, 24'hFFFFFF));
        foreach (ref_values[k]) begin
            if (k != 0) write_reference(ref_values[k]);
            // a sample exactly at the reference reads as zero altitude
            if (ref_values[k] != 0)
                send_sample(24'($urandom()), ref_values[k], 1'b1, 32'sd0);
            repeat (265) send_sample(24'($urandom()), random_pressure(), 1'b0, 32'sd0);
        end
        s_axis_tvalid <= 1'b0;

        while (altitude_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
